// ===== rtl/core/aqi_pkg.sv =====
package aqi_pkg;

  // Field widths.
  localparam int unsigned V_W   = 16;
  localparam int unsigned OUT_W = 20;
  localparam int unsigned IN_DATA_W  = 2 * V_W;
  localparam int unsigned OUT_DATA_W = 2 * OUT_W;

  localparam int unsigned MAX_CONCENTRATION_DEFAULT = 1000;

  // Index arithmetic: Q.4 results, breakpoints held in tenths.
  localparam int unsigned FRAC_ONE = 16;
  localparam int unsigned TENTHS   = 10;

  // Segment tables; the last segment's upper breakpoint and index come
  // from MAX_CONCENTRATION, so the last entries of the HI and B tables are unused.
  localparam int unsigned SEG_N = 6;
  localparam int unsigned SEG_W = $clog2(SEG_N);

  localparam int unsigned PM25_VLIM [SEG_N-1] = '{9, 35, 55, 125, 225};
  localparam int unsigned PM25_LO   [SEG_N]   = '{0, 91, 355, 555, 1255, 2255};
  localparam int unsigned PM25_HI   [SEG_N]   = '{90, 354, 554, 1254, 2254, 0};
  localparam int unsigned PM10_VLIM [SEG_N-1] = '{54, 154, 254, 354, 424};
  localparam int unsigned PM10_LO   [SEG_N]   = '{0, 550, 1550, 2550, 3550, 4250};
  localparam int unsigned PM10_HI   [SEG_N]   = '{540, 1540, 2540, 3540, 4240, 0};
  localparam int unsigned IDX_A     [SEG_N]   = '{0, 51, 101, 151, 201, 301};
  localparam int unsigned IDX_B     [SEG_N]   = '{50, 100, 150, 200, 300, 0};

  // Datapath widths, sized for the whole MAX_CONCENTRATION range.
  localparam int unsigned DIGIT_W     = 8;   // concentration split into two digits
  localparam int unsigned D_W         = 21;  // divisor, twice the segment span
  localparam int unsigned M_W         = 23;  // reciprocal of the divisor
  localparam int unsigned IP_W        = 8;   // whole part of the slope
  localparam int unsigned IH_W        = DIGIT_W;
  localparam int unsigned K_W         = 20;  // signed offset
  localparam int unsigned N2_W        = 30;  // residual numerator
  localparam int unsigned Q_W         = 10;  // residual quotient
  localparam int unsigned S_W         = 26;  // signed index sum
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned PR_W        = Q_W + D_W;
  localparam int unsigned EST_W       = N2_W + M_W;

  localparam logic [OUT_W-1:0] AQI_SAT = '1;

  // Pipeline stages.
  localparam int unsigned STAGE_N = 5;
  localparam int unsigned ST_IN   = 0;
  localparam int unsigned ST_MAP  = 1;
  localparam int unsigned ST_EST  = 2;
  localparam int unsigned ST_PROD = 3;
  localparam int unsigned ST_OUT  = 4;

  typedef struct packed {
    logic [STAGE_N-1:0] load;
    logic [STAGE_N-1:0] valid;
    logic               in_ready;
  } aqi_flow_t;

endpackage

// ===== rtl/core/aqi_flow_ctrl.sv =====
module aqi_flow_ctrl import aqi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  input  logic      m_ready_i,
  output aqi_flow_t flow_o
);

  logic [STAGE_N-1:0] valid_q, valid_d, rdy, load;

  // A stage may take a new item when it is empty or its item moves on.
  always_comb begin
    rdy[STAGE_N-1] = !valid_q[STAGE_N-1] || m_ready_i;
    for (int k = STAGE_N - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    load[0]    = rdy[0] && s_valid_i;
    valid_d[0] = rdy[0] ? s_valid_i : valid_q[0];
    for (int k = 1; k < STAGE_N; k++) begin
      load[k]    = rdy[k] && valid_q[k-1];
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign flow_o.load     = load;
  assign flow_o.valid    = valid_q;
  assign flow_o.in_ready = rdy[0];

endmodule

// ===== rtl/core/aqi_seg_map.sv =====
module aqi_seg_map import aqi_pkg::*; #(
  parameter bit          IS_PM10           = 1'b0,
  parameter int unsigned MAX_CONCENTRATION = MAX_CONCENTRATION_DEFAULT
) (
  input  logic                   clk_i,
  input  aqi_flow_t              flow_i,
  input  logic [V_W-1:0]         conc_i,
  output logic [N2_W-1:0]        n2_o,
  output logic signed [S_W-1:0]  base_o,
  output logic [D_W-1:0]         d_o,
  output logic [M_W-1:0]         m_o
);

  // Per segment the index is a*16 + floor((P*v + Z) / D). With P = Ip*D + Rp,
  // Z = Iz*D + Rz and Rp*256 = Ih*D + Rh this becomes
  //   K + Ip*v + Ih*vh + floor((Rh*vh + Rp*vl + Rz) / D),
  // where the residual numerator stays below about 511*D.
  logic [D_W-1:0]         seg_d  [SEG_N];
  logic [M_W-1:0]         seg_m  [SEG_N];
  logic [IP_W-1:0]        seg_ip [SEG_N];
  logic [IH_W-1:0]        seg_ih [SEG_N];
  logic [D_W-1:0]         seg_rp [SEG_N];
  logic [D_W-1:0]         seg_rh [SEG_N];
  logic [D_W-1:0]         seg_rz [SEG_N];
  logic signed [K_W-1:0]  seg_k  [SEG_N];

  for (genvar g = 0; g < SEG_N; g++) begin : g_seg
    localparam longint Lo = IS_PM10 ? longint'(PM10_LO[g]) : longint'(PM25_LO[g]);
    localparam longint Hi = (g == SEG_N - 1) ? longint'(MAX_CONCENTRATION) * TENTHS :
                            (IS_PM10 ? longint'(PM10_HI[g]) : longint'(PM25_HI[g]));
    localparam longint Ia = longint'(IDX_A[g]);
    localparam longint Ib = (g == SEG_N - 1) ? longint'(MAX_CONCENTRATION) :
                            longint'(IDX_B[g]);
    localparam longint Span = Hi - Lo;
    localparam longint Dv   = 2 * Span;
    localparam longint Pv   = 2 * FRAC_ONE * TENTHS * (Ib - Ia);
    localparam longint Zv   = Span - 2 * FRAC_ONE * (Ib - Ia) * Lo;
    localparam longint Ipv  = Pv / Dv;
    localparam longint Rpv  = Pv % Dv;
    localparam longint Izv  = (Zv >= 0) ? Zv / Dv : -((Dv - 1 - Zv) / Dv);
    localparam longint Rzv  = Zv - Izv * Dv;
    localparam longint Ihv  = (Rpv * (longint'(1) << DIGIT_W)) / Dv;
    localparam longint Rhv  = (Rpv * (longint'(1) << DIGIT_W)) % Dv;
    localparam longint Mv   = (longint'(1) << RECIP_SHIFT) / Dv;
    localparam longint Kv   = Ia * FRAC_ONE + Izv;

    assign seg_d[g]  = D_W'(Dv);
    assign seg_m[g]  = M_W'(Mv);
    assign seg_ip[g] = IP_W'(Ipv);
    assign seg_ih[g] = IH_W'(Ihv);
    assign seg_rp[g] = D_W'(Rpv);
    assign seg_rh[g] = D_W'(Rhv);
    assign seg_rz[g] = D_W'(Rzv);
    assign seg_k[g]  = K_W'(Kv);
  end

  // Input stage: register the concentration and its segment.
  logic [SEG_W-1:0] seg_d0, seg_q;
  logic [V_W-1:0]   v_q;

  always_comb begin
    seg_d0 = '0;
    for (int i = 0; i < SEG_N - 1; i++) begin
      if (conc_i > V_W'(IS_PM10 ? PM10_VLIM[i] : PM25_VLIM[i])) begin
        seg_d0 = seg_d0 + SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.load[ST_IN]) begin
      v_q   <= conc_i;
      seg_q <= seg_d0;
    end
  end

  // Map stage: constant-coefficient products.
  logic [DIGIT_W-1:0]      vh, vl;
  logic [D_W+DIGIT_W-1:0]  p_rh, p_rp;
  logic [IP_W+V_W-1:0]     p_ip;
  logic [2*DIGIT_W-1:0]    p_ih;
  logic [N2_W-1:0]         n2_d;
  logic signed [S_W-1:0]   base_d;
  logic signed [K_W-1:0]   k_sel;

  assign vh    = v_q[V_W-1:DIGIT_W];
  assign vl    = v_q[DIGIT_W-1:0];
  assign k_sel = seg_k[seg_q];

  always_comb begin
    p_rh   = (D_W+DIGIT_W)'(seg_rh[seg_q]) * (D_W+DIGIT_W)'(vh);
    p_rp   = (D_W+DIGIT_W)'(seg_rp[seg_q]) * (D_W+DIGIT_W)'(vl);
    p_ip   = (IP_W+V_W)'(seg_ip[seg_q]) * (IP_W+V_W)'(v_q);
    p_ih   = (2*DIGIT_W)'(seg_ih[seg_q]) * (2*DIGIT_W)'(vh);
    n2_d   = N2_W'(p_rh) + N2_W'(p_rp) + N2_W'(seg_rz[seg_q]);
    base_d = $signed({{(S_W-K_W){k_sel[K_W-1]}}, k_sel})
           + $signed({{(S_W-IP_W-V_W){1'b0}}, p_ip})
           + $signed({{(S_W-2*DIGIT_W){1'b0}}, p_ih});
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.load[ST_MAP]) begin
      n2_o   <= n2_d;
      base_o <= base_d;
      d_o    <= seg_d[seg_q];
      m_o    <= seg_m[seg_q];
    end
  end

endmodule

// ===== rtl/core/aqi_div_sat.sv =====
module aqi_div_sat import aqi_pkg::*; (
  input  logic                   clk_i,
  input  aqi_flow_t              flow_i,
  input  logic [N2_W-1:0]        n2_i,
  input  logic signed [S_W-1:0]  base_i,
  input  logic [D_W-1:0]         d_i,
  input  logic [M_W-1:0]         m_i,
  output logic [OUT_W-1:0]       aqi_o
);

  // Estimate stage: the truncated reciprocal gives the quotient or one less.
  logic [EST_W-1:0]      est;
  logic [Q_W-1:0]        qest_q;
  logic [N2_W-1:0]       n2_e_q;
  logic signed [S_W-1:0] base_e_q;
  logic [D_W-1:0]        d_e_q;

  assign est = EST_W'(n2_i) * EST_W'(m_i);

  always_ff @(posedge clk_i) begin
    if (flow_i.load[ST_EST]) begin
      qest_q   <= est[RECIP_SHIFT +: Q_W];
      n2_e_q   <= n2_i;
      base_e_q <= base_i;
      d_e_q    <= d_i;
    end
  end

  // Product stage: back-multiply the estimate.
  logic [PR_W-1:0]       prod_q;
  logic [Q_W-1:0]        qest_p_q;
  logic [N2_W-1:0]       n2_p_q;
  logic signed [S_W-1:0] base_p_q;
  logic [D_W-1:0]        d_p_q;

  always_ff @(posedge clk_i) begin
    if (flow_i.load[ST_PROD]) begin
      prod_q   <= PR_W'(qest_q) * PR_W'(d_e_q);
      qest_p_q <= qest_q;
      n2_p_q   <= n2_e_q;
      base_p_q <= base_e_q;
      d_p_q    <= d_e_q;
    end
  end

  // Output stage: correct the estimate, add the offset and saturate.
  logic [N2_W-1:0]       rem;
  logic [Q_W-1:0]        q_fix;
  logic signed [S_W-1:0] total;
  logic [OUT_W-1:0]      aqi_d;

  always_comb begin
    rem   = n2_p_q - prod_q[N2_W-1:0];
    q_fix = qest_p_q + Q_W'(rem >= N2_W'(d_p_q));
    total = base_p_q + $signed({{(S_W-Q_W){1'b0}}, q_fix});
    if (total[S_W-1]) begin
      aqi_d = '0;
    end else if (total > $signed({{(S_W-OUT_W){1'b0}}, AQI_SAT})) begin
      aqi_d = AQI_SAT;
    end else begin
      aqi_d = total[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.load[ST_OUT]) begin
      aqi_o <= aqi_d;
    end
  end

endmodule

// ===== rtl/core/particulate_aqi_calculator.sv =====
// Particulate air quality index: PM2.5 and PM10 mapped to Q16.4 index values.
// Pipeline: each item passes through five register stages (input, segment map,
// reciprocal estimate, product, output).
// Throughput: one item per cycle while the output is taken; a full stage holds while the next one cannot take its item.
// Reset: asynchronous and active low, clears the stage valid bits only.
module particulate_aqi_calculator import aqi_pkg::*; #(
  parameter int unsigned MAX_CONCENTRATION = MAX_CONCENTRATION_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] pm2_5_concentration, [31:16] pm10_concentration
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [19:0] aqi_pm2_5, [39:20] aqi_pm10
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  aqi_flow_t flow;

  aqi_flow_ctrl u_flow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .flow_o    (flow)
  );

  assign s_axis_tready = flow.in_ready;
  assign m_axis_tvalid = flow.valid[ST_OUT];

  logic [N2_W-1:0]        n2_25, n2_10;
  logic signed [S_W-1:0]  base_25, base_10;
  logic [D_W-1:0]         d_25, d_10;
  logic [M_W-1:0]         m_25, m_10;
  logic [OUT_W-1:0]       aqi_25, aqi_10;

  aqi_seg_map #(
    .IS_PM10           (1'b0),
    .MAX_CONCENTRATION (MAX_CONCENTRATION)
  ) u_map_pm25 (
    .clk_i  (clk_i),
    .flow_i (flow),
    .conc_i (s_axis_tdata[V_W-1:0]),
    .n2_o   (n2_25),
    .base_o (base_25),
    .d_o    (d_25),
    .m_o    (m_25)
  );

  aqi_seg_map #(
    .IS_PM10           (1'b1),
    .MAX_CONCENTRATION (MAX_CONCENTRATION)
  ) u_map_pm10 (
    .clk_i  (clk_i),
    .flow_i (flow),
    .conc_i (s_axis_tdata[2*V_W-1:V_W]),
    .n2_o   (n2_10),
    .base_o (base_10),
    .d_o    (d_10),
    .m_o    (m_10)
  );

  aqi_div_sat u_div_pm25 (
    .clk_i  (clk_i),
    .flow_i (flow),
    .n2_i   (n2_25),
    .base_i (base_25),
    .d_i    (d_25),
    .m_i    (m_25),
    .aqi_o  (aqi_25)
  );

  aqi_div_sat u_div_pm10 (
    .clk_i  (clk_i),
    .flow_i (flow),
    .n2_i   (n2_10),
    .base_i (base_10),
    .d_i    (d_10),
    .m_i    (m_10),
    .aqi_o  (aqi_10)
  );

  assign m_axis_tdata = {aqi_10, aqi_25};

`ifndef SYNTHESIS
  // With the output free, every stage can move, so the input must be ready.
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while the output stage was free");

  // A new result only comes from the product stage.
  a_out_from_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(flow.valid[ST_PROD]))
    else $error("result appeared without an item in the product stage");

  // An item entering an empty pipeline is offered at the output once it has passed every stage.
  a_empty_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (flow.valid == '0)) |-> ##5 m_axis_tvalid)
    else $error("item lost in an empty pipeline");
`endif

endmodule

// ===== test/particulate_aqi_calculator_tb.sv =====
module particulate_aqi_calculator_tb;
  import aqi_pkg::*;

  localparam int unsigned TOP_CONC = MAX_CONCENTRATION_DEFAULT;

  typedef struct {
    logic [V_W-1:0]   pm2_5_in;
    logic [V_W-1:0]   pm10_in;
    logic [OUT_W-1:0] aqi_pm2_5;
    logic [OUT_W-1:0] aqi_pm10;
  } aqi_pair_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  aqi_pair_t aqi_expected_q[$];
  int        mismatch_cnt = 0;
  int        rx_stall_left = 0;
  logic      idle_on;

  particulate_aqi_calculator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // One interpolation segment; x and the breakpoints are in tenths of ug/m3.
  function automatic logic [OUT_W-1:0] interp_segment(longint unsigned x, longint unsigned lo,
                                                      longint unsigned hi, longint unsigned a,
                                                      longint unsigned b);
    longint unsigned span;
    longint unsigned num;
    longint unsigned q;
    if (hi <= lo || b < a || x < lo) begin
      return AQI_SAT;
    end
    span = hi - lo;
    num  = (x - lo) * (b - a) * 16;
    q    = a * 16 + (2 * num + span) / (2 * span);
    if (q > 64'hFFFFF) begin
      return AQI_SAT;
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] pm2_5_index(logic [V_W-1:0] v);
    longint unsigned x;
    x = longint'(v) * 10;
    if (v <= 9)   return interp_segment(x, 0, 90, 0, 50);
    if (v <= 35)  return interp_segment(x, 91, 354, 51, 100);
    if (v <= 55)  return interp_segment(x, 355, 554, 101, 150);
    if (v <= 125) return interp_segment(x, 555, 1254, 151, 200);
    if (v <= 225) return interp_segment(x, 1255, 2254, 201, 300);
    return interp_segment(x, 2255, TOP_CONC * 10, 301, TOP_CONC);
  endfunction

  function automatic logic [OUT_W-1:0] pm10_index(logic [V_W-1:0] v);
    longint unsigned x;
    x = longint'(v) * 10;
    if (v <= 54)  return interp_segment(x, 0, 540, 0, 50);
    if (v <= 154) return interp_segment(x, 550, 1540, 51, 100);
    if (v <= 254) return interp_segment(x, 1550, 2540, 101, 150);
    if (v <= 354) return interp_segment(x, 2550, 3540, 151, 200);
    if (v <= 424) return interp_segment(x, 3550, 4240, 201, 300);
    return interp_segment(x, 4250, TOP_CONC * 10, 301, TOP_CONC);
  endfunction

  task automatic send_item(input logic [V_W-1:0] pm2_5, input logic [V_W-1:0] pm10);
    aqi_pair_t exp_pair;
    int        gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pm10, pm2_5};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_pair.pm2_5_in  = pm2_5;
    exp_pair.pm10_in   = pm10;
    exp_pair.aqi_pm2_5 = pm2_5_index(pm2_5);
    exp_pair.aqi_pm10  = pm10_index(pm10);
    aqi_expected_q.push_back(exp_pair);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (aqi_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly realistic readings, with some mid-range and some anywhere in 16 bits.
  function automatic logic [V_W-1:0] rand_concentration();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return V_W'($urandom_range(0, 500));
    if (pick < 8) return V_W'($urandom_range(0, 1500));
    return V_W'($urandom);
  endfunction

  task automatic apply_reset();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    idle_on       <= 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Both sides of every segment boundary, the extremes, and the top breakpoint.
  task automatic test_segment_edges();
    int unsigned pm2_5_pts[$] = '{0, 9, 10, 35, 36, 55, 56, 125, 126, 225, 226, 1000, 1001,
                                  65535, 1, 12, 300, 32768};
    int unsigned pm10_pts[$]  = '{0, 54, 55, 154, 155, 254, 255, 354, 355, 424, 425, 1000,
                                  1001, 65535, 65535, 0, 50000, 32768};
    foreach (pm2_5_pts[i]) begin
      send_item(V_W'(pm2_5_pts[i]), V_W'(pm10_pts[i]));
    end
    send_item('1, '0);
    send_item('0, '1);
    send_item(16'h5555, 16'hAAAA);
    send_item(16'hAAAA, 16'h5555);
    wait_drained();
  endtask

  task automatic test_random_readings(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) == 0) begin
        idle_on <= ~idle_on;
      end
      send_item(rand_concentration(), rand_concentration());
    end
    idle_on <= 1'b1;
  endtask

  // The sender holds off until the pipeline is empty, now and then.
  task automatic test_drain_pauses(input int count);
    repeat (count) begin
      send_item(rand_concentration(), rand_concentration());
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  task automatic test_back_to_back(input int count);
    idle_on <= 1'b0;
    repeat (count) begin
      send_item(rand_concentration(), rand_concentration());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    aqi_pair_t exp_pair;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (aqi_expected_q.size() == 0) begin
        $error("unexpected result item, tdata %h", m_axis_tdata);
        mismatch_cnt++;
      end else begin
        exp_pair = aqi_expected_q.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== exp_pair.aqi_pm2_5) begin
          $error("aqi_pm2_5 (pm2_5 %0d): expected %h, actual %h", exp_pair.pm2_5_in,
                 exp_pair.aqi_pm2_5, m_axis_tdata[OUT_W-1:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[2*OUT_W-1:OUT_W] !== exp_pair.aqi_pm10) begin
          $error("aqi_pm10 (pm10 %0d): expected %h, actual %h", exp_pair.pm10_in,
                 exp_pair.aqi_pm10, m_axis_tdata[2*OUT_W-1:OUT_W]);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    apply_reset();
    test_segment_edges();
    test_random_readings(900);
    test_drain_pauses(100);
    test_back_to_back(200);
    while (aqi_expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (aqi_expected_q.size() != 0) begin
      $error("%0d expected results never arrived", aqi_expected_q.size());
    end
    if (mismatch_cnt == 0 && aqi_expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
